>>> sv/repeating_timer_queue_core_defines.svh
// Assertion macros for the timer queue. Each macro samples on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef REPEATING_TIMER_QUEUE_CORE_DEFINES_SVH
`define REPEATING_TIMER_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RTQ_ASSERT(lbl, prop, msg)
`define RTQ_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

>>> sv/rtq_pkg.sv
package rtq_pkg;

  localparam int NOW_W    = 48;
  localparam int PERIOD_W = 32;
  localparam int REP_W    = 16;
  localparam int TAG_W    = 32;
  localparam int REM_W    = 33;
  localparam int MINP_W   = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int MAX_FIRES  = 16;

  localparam logic [MINP_W-1:0] MIN_PERIOD_RST = 16'd10;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_CREATED   = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_DESTROYED = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_FIRED     = 3'd4,
    KIND_REPORT    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ORD_NONE   = 2'd0,
    ORD_INSERT = 2'd1,
    ORD_REMOVE = 2'd2
  } ord_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_Q_RD,
    S_Q_CALC,
    S_DUE_RD,
    S_DUE_CMP,
    S_DUE_END,
    S_FIRE_RD,
    S_FIRE_PROC,
    S_FIRE_NEXT,
    S_INS_RD,
    S_INS_CMP
  } state_t;

  // One timer as held in the entry memory.
  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [REP_W-1:0] rep;
    logic [PERIOD_W-1:0]     period;
    logic [NOW_W-1:0]        deadline;
  } entry_t;

endpackage

>>> sv/repeating_timer_queue_core.sv
// Timer queue with up to TIMERS repeating timers kept in deadline order, a
// millisecond clock advanced by tick commands, and an APB register for the
// smallest accepted period. Each command is taken alone: in_tready is high
// only while the block is idle. A create finds its insertion point by reading
// the entry memory one queued timer at a time through its single read port
// and comparing with the one shared 48-bit adder/subtractor. A tick first
// counts the due timers, then fires them one by one and requeues a timer
// that repeats in the same way. A result waiting in the output register
// stalls the sequencer until it is taken. No memory clearing pass is needed
// after reset.
`include "repeating_timer_queue_core_defines.svh"

module repeating_timer_queue_core #(
  parameter int TIMERS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: period_ms[31:0], repeat_count[47:32], user_tag[79:48],
  //           target_id[83:80], zero fill [87:84]
  input  logic [87:0]  in_tdata,
  // in_tuser: command[1:0]
  input  logic [1:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: slot_id[3:0], fired_tag[35:4], remaining_ms[68:36],
  //            zero fill [71:69]
  output logic [71:0]  out_tdata,
  // out_tuser: kind[2:0]
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int SLOT_W   = $clog2(TIMERS);
  localparam int CNT_W    = $clog2(TIMERS + 1);
  localparam int FIRE_CAP = (TIMERS < rtq_pkg::MAX_FIRES) ? TIMERS : rtq_pkg::MAX_FIRES;
  localparam int NOW_W    = rtq_pkg::NOW_W;
  localparam int REM_W    = rtq_pkg::REM_W;
  localparam int TAG_W    = rtq_pkg::TAG_W;
  localparam int SO_W     = rtq_pkg::SLOT_OUT_W;

  // Input fields.
  logic [rtq_pkg::PERIOD_W-1:0]     in_period;
  logic signed [rtq_pkg::REP_W-1:0] in_rep;
  logic [TAG_W-1:0]                 in_tag;
  logic [3:0]                       in_target;
  rtq_pkg::cmd_t                    in_cmd;

  assign in_period = in_tdata[31:0];
  assign in_rep    = $signed(in_tdata[47:32]);
  assign in_tag    = in_tdata[79:48];
  assign in_target = in_tdata[83:80];
  assign in_cmd    = rtq_pkg::cmd_t'(in_tuser);

  // Registers.
  rtq_pkg::state_t              state_r, state_nxt;
  rtq_pkg::state_t              after_r, after_nxt;
  rtq_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [CNT_W-1:0]             pos_r, pos_nxt;
  logic [CNT_W-1:0]             due_r, due_nxt;
  logic [CNT_W-1:0]             fired_r, fired_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [NOW_W-1:0]             d_r, d_nxt;
  logic [NOW_W-1:0]             now_r, now_nxt;
  logic [TIMERS-1:0]            valid_r, valid_nxt;
  logic [rtq_pkg::MINP_W-1:0]   min_period_r;
  rtq_pkg::kind_t               res_kind_r, res_kind_nxt;
  logic [SO_W-1:0]              res_slot_r, res_slot_nxt;
  logic [TAG_W-1:0]             res_tag_r, res_tag_nxt;
  logic [REM_W-1:0]             res_rem_r, res_rem_nxt;
  logic                         res_last_r, res_last_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  rtq_pkg::kind_t               out_kind_r, out_kind_nxt;
  logic [SO_W-1:0]              out_slot_r, out_slot_nxt;
  logic [TAG_W-1:0]             out_tag_r, out_tag_nxt;
  logic [REM_W-1:0]             out_rem_r, out_rem_nxt;
  logic                         out_last_r, out_last_nxt;

  // Shared unit, entry memory and order list connections.
  logic [NOW_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_sub, alu_carry;
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  rtq_pkg::entry_t    ram_wdata, ram_rdata;
  rtq_pkg::ord_op_t   ord_op;
  logic [SLOT_W-1:0]  ord_pos, ord_slot, rd_slot, find_pos;
  logic [CNT_W-1:0]   count;
  logic [SLOT_W-1:0]  free_slot;
  logic [SLOT_W-1:0]  tgt_idx;
  logic               tgt_ok;
  logic signed [rtq_pkg::REP_W-1:0] rep_new;

  rtq_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_res),
    .carry  (alu_carry)
  );

  rtq_ram #(
    .WIDTH ($bits(rtq_pkg::entry_t)),
    .DEPTH (TIMERS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  rtq_order #(
    .TIMERS (TIMERS)
  ) u_order (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (ord_op),
    .pos       (ord_pos),
    .slot      (ord_slot),
    .rd_pos    (pos_r[SLOT_W-1:0]),
    .find_slot (tgt_idx),
    .rd_slot   (rd_slot),
    .find_pos  (find_pos),
    .count     (count)
  );

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign tgt_ok  = {28'd0, in_target} < 32'(TIMERS);
  assign tgt_idx = SLOT_W'(in_target);
  assign rep_new = (ram_rdata.rep > 0) ? ram_rdata.rep - 16'sd1 : ram_rdata.rep;

  assign in_tready = (state_r == rtq_pkg::S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    after_nxt    = after_r;
    cmd_nxt      = cmd_r;
    pos_nxt      = pos_r;
    due_nxt      = due_r;
    fired_nxt    = fired_r;
    slot_nxt     = slot_r;
    d_nxt        = d_r;
    now_nxt      = now_r;
    valid_nxt    = valid_r;
    res_kind_nxt = res_kind_r;
    res_slot_nxt = res_slot_r;
    res_tag_nxt  = res_tag_r;
    res_rem_nxt  = res_rem_r;
    res_last_nxt = res_last_r;
    alu_a        = now_r;
    alu_b        = NOW_W'(1);
    alu_sub      = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = slot_r;
    ram_wdata    = ram_rdata;
    ord_op       = rtq_pkg::ORD_NONE;
    ord_pos      = '0;
    ord_slot     = slot_r;

    unique case (state_r)
      rtq_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_cmd;
          res_slot_nxt = '0;
          res_tag_nxt  = '0;
          res_rem_nxt  = '0;
          res_last_nxt = 1'b1;
          after_nxt    = rtq_pkg::S_IDLE;
          pos_nxt      = '0;
          unique case (in_cmd)
            rtq_pkg::CMD_CREATE: begin
              alu_b = NOW_W'(in_period);
              if (in_period < 32'(min_period_r) || count == CNT_W'(TIMERS)) begin
                res_kind_nxt = rtq_pkg::KIND_REJECTED;
                state_nxt    = rtq_pkg::S_EMIT;
              end else begin
                ram_we                = 1'b1;
                ram_waddr             = free_slot;
                ram_wdata.tag         = in_tag;
                ram_wdata.rep         = in_rep;
                ram_wdata.period      = in_period;
                ram_wdata.deadline    = alu_res;
                valid_nxt[free_slot]  = 1'b1;
                slot_nxt              = free_slot;
                d_nxt                 = alu_res;
                state_nxt             = rtq_pkg::S_INS_RD;
              end
            end
            rtq_pkg::CMD_DESTROY: begin
              if (tgt_ok && valid_r[tgt_idx]) begin
                ord_op             = rtq_pkg::ORD_REMOVE;
                ord_pos            = find_pos;
                valid_nxt[tgt_idx] = 1'b0;
                res_kind_nxt       = rtq_pkg::KIND_DESTROYED;
                res_slot_nxt       = in_target;
              end else begin
                res_kind_nxt = rtq_pkg::KIND_NOT_FOUND;
              end
              state_nxt = rtq_pkg::S_EMIT;
            end
            rtq_pkg::CMD_TICK: begin
              now_nxt   = alu_res;
              state_nxt = rtq_pkg::S_DUE_RD;
            end
            rtq_pkg::CMD_QUERY: begin
              if (count == '0) begin
                res_kind_nxt = rtq_pkg::KIND_REPORT;
                res_rem_nxt  = '1;
                state_nxt    = rtq_pkg::S_EMIT;
              end else begin
                state_nxt = rtq_pkg::S_Q_RD;
              end
            end
          endcase
        end
      end

      rtq_pkg::S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = after_r;
        end
      end

      rtq_pkg::S_Q_RD: begin
        state_nxt = rtq_pkg::S_Q_CALC;
      end

      rtq_pkg::S_Q_CALC: begin
        alu_a        = ram_rdata.deadline;
        alu_b        = now_r;
        alu_sub      = 1'b1;
        res_kind_nxt = rtq_pkg::KIND_REPORT;
        // An overdue head reports one millisecond; long waits saturate.
        if (!alu_carry) begin
          res_rem_nxt = REM_W'(1);
        end else if (|alu_res[NOW_W-1:32]) begin
          res_rem_nxt = {1'b0, 32'hFFFF_FFFF};
        end else begin
          res_rem_nxt = {1'b0, alu_res[31:0]};
        end
        after_nxt = rtq_pkg::S_IDLE;
        state_nxt = rtq_pkg::S_EMIT;
      end

      rtq_pkg::S_DUE_RD: begin
        if (pos_r == count || pos_r == CNT_W'(FIRE_CAP)) begin
          state_nxt = rtq_pkg::S_DUE_END;
        end else begin
          state_nxt = rtq_pkg::S_DUE_CMP;
        end
      end

      rtq_pkg::S_DUE_CMP: begin
        alu_a   = now_r;
        alu_b   = ram_rdata.deadline;
        alu_sub = 1'b1;
        if (alu_carry) begin
          pos_nxt   = pos_r + CNT_W'(1);
          state_nxt = rtq_pkg::S_DUE_RD;
        end else begin
          state_nxt = rtq_pkg::S_DUE_END;
        end
      end

      rtq_pkg::S_DUE_END: begin
        if (pos_r == '0) begin
          state_nxt = rtq_pkg::S_IDLE;
        end else begin
          due_nxt   = pos_r;
          fired_nxt = '0;
          pos_nxt   = '0;
          state_nxt = rtq_pkg::S_FIRE_RD;
        end
      end

      rtq_pkg::S_FIRE_RD: begin
        slot_nxt  = rd_slot;
        state_nxt = rtq_pkg::S_FIRE_PROC;
      end

      rtq_pkg::S_FIRE_PROC: begin
        res_kind_nxt = rtq_pkg::KIND_FIRED;
        res_slot_nxt = SO_W'(slot_r);
        res_tag_nxt  = ram_rdata.tag;
        res_rem_nxt  = '0;
        res_last_nxt = (fired_r + CNT_W'(1)) == due_r;
        fired_nxt    = fired_r + CNT_W'(1);
        ord_op       = rtq_pkg::ORD_REMOVE;
        ord_pos      = '0;
        pos_nxt      = '0;
        if (rep_new == '0) begin
          valid_nxt[slot_r] = 1'b0;
          after_nxt         = rtq_pkg::S_FIRE_NEXT;
        end else begin
          alu_a              = now_r;
          alu_b              = NOW_W'(ram_rdata.period);
          ram_we             = 1'b1;
          ram_wdata.rep      = rep_new;
          ram_wdata.deadline = alu_res;
          d_nxt              = alu_res;
          after_nxt          = rtq_pkg::S_INS_RD;
        end
        state_nxt = rtq_pkg::S_EMIT;
      end

      rtq_pkg::S_FIRE_NEXT: begin
        if (fired_r == due_r) begin
          state_nxt = rtq_pkg::S_IDLE;
        end else begin
          pos_nxt   = '0;
          state_nxt = rtq_pkg::S_FIRE_RD;
        end
      end

      rtq_pkg::S_INS_RD, rtq_pkg::S_INS_CMP: begin
        alu_a   = d_r;
        alu_b   = ram_rdata.deadline;
        alu_sub = 1'b1;
        if (state_r == rtq_pkg::S_INS_RD && pos_r != count) begin
          state_nxt = rtq_pkg::S_INS_CMP;
        end else if (state_r == rtq_pkg::S_INS_CMP && alu_carry) begin
          // Equal deadlines keep their queueing order.
          pos_nxt   = pos_r + CNT_W'(1);
          state_nxt = rtq_pkg::S_INS_RD;
        end else begin
          ord_op  = rtq_pkg::ORD_INSERT;
          ord_pos = pos_r[SLOT_W-1:0];
          if (cmd_r == rtq_pkg::CMD_CREATE) begin
            res_kind_nxt = rtq_pkg::KIND_CREATED;
            res_slot_nxt = SO_W'(slot_r);
            res_tag_nxt  = '0;
            res_rem_nxt  = '0;
            res_last_nxt = 1'b1;
            after_nxt    = rtq_pkg::S_IDLE;
            state_nxt    = rtq_pkg::S_EMIT;
          end else begin
            state_nxt = rtq_pkg::S_FIRE_NEXT;
          end
        end
      end

      default: state_nxt = rtq_pkg::S_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_tag_nxt    = out_tag_r;
    out_rem_nxt    = out_rem_r;
    out_last_nxt   = out_last_r;
    if (state_r == rtq_pkg::S_EMIT && (!out_tvalid_r || out_tready)) begin
      out_tvalid_nxt = 1'b1;
      out_kind_nxt   = res_kind_r;
      out_slot_nxt   = res_slot_r;
      out_tag_nxt    = res_tag_r;
      out_rem_nxt    = res_rem_r;
      out_last_nxt   = res_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rtq_pkg::S_IDLE;
      after_r      <= rtq_pkg::S_IDLE;
      cmd_r        <= rtq_pkg::CMD_CREATE;
      pos_r        <= '0;
      due_r        <= '0;
      fired_r      <= '0;
      now_r        <= '0;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      after_r      <= after_nxt;
      cmd_r        <= cmd_nxt;
      pos_r        <= pos_nxt;
      due_r        <= due_nxt;
      fired_r      <= fired_nxt;
      now_r        <= now_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    d_r        <= d_nxt;
    res_kind_r <= res_kind_nxt;
    res_slot_r <= res_slot_nxt;
    res_tag_r  <= res_tag_nxt;
    res_rem_r  <= res_rem_nxt;
    res_last_r <= res_last_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_tag_r  <= out_tag_nxt;
    out_rem_r  <= out_rem_nxt;
    out_last_r <= out_last_nxt;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= rtq_pkg::MIN_PERIOD_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      min_period_r <= cfg_pwdata[rtq_pkg::MINP_W-1:0];
    end
  end

  always_comb begin
    if (!cfg_paddr[2]) begin
      cfg_prdata = {{(32 - rtq_pkg::MINP_W){1'b0}}, min_period_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  assign cfg_pready = 1'b1;

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_rem_r, out_tag_r, out_slot_r};

  // The count of queued timers matches the allocated slots whenever idle.
  `RTQ_ASSERT_IMPL(a_idle_count, state_r == rtq_pkg::S_IDLE, $countones(valid_r) == count, "queue count differs from allocated slots")
  // Every accepted command takes the sequencer out of the idle state.
  `RTQ_ASSERT(a_accept_busy, (in_tvalid && in_tready) |=> (state_r != rtq_pkg::S_IDLE), "command accepted but sequencer stayed idle")
  // Only firings may come several to one command.
  `RTQ_ASSERT_IMPL(a_single_last, out_tvalid && out_tuser != rtq_pkg::KIND_FIRED, out_tlast, "single result without last")
  // The firing count never runs past the due count.
  `RTQ_ASSERT(a_fire_bound, fired_r <= due_r || state_r == rtq_pkg::S_IDLE || state_r == rtq_pkg::S_DUE_RD || state_r == rtq_pkg::S_DUE_CMP || state_r == rtq_pkg::S_DUE_END, "more timers fired than were due")

endmodule

>>> sv/rtq_ram.sv
module rtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rtq_alu.sv
// Shared 48-bit adder/subtractor. In subtract mode carry is set when a >= b.
module rtq_alu (
  input  logic [rtq_pkg::NOW_W-1:0] a,
  input  logic [rtq_pkg::NOW_W-1:0] b,
  input  logic                      sub,
  output logic [rtq_pkg::NOW_W-1:0] result,
  output logic                      carry
);

  logic [rtq_pkg::NOW_W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign {carry, result} = {1'b0, a} + {1'b0, b_op} + {{rtq_pkg::NOW_W{1'b0}}, sub};

endmodule

>>> sv/rtq_order.sv
// Due-order list: slot numbers, earliest deadline first. Lanes from pos on
// shift headward on a removal, lanes past pos tailward on an insert.
module rtq_order #(
  parameter int TIMERS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rtq_pkg::ord_op_t              op,
  input  logic [$clog2(TIMERS)-1:0]     pos,
  input  logic [$clog2(TIMERS)-1:0]     slot,
  input  logic [$clog2(TIMERS)-1:0]     rd_pos,
  input  logic [$clog2(TIMERS)-1:0]     find_slot,
  output logic [$clog2(TIMERS)-1:0]     rd_slot,
  output logic [$clog2(TIMERS)-1:0]     find_pos,
  output logic [$clog2(TIMERS+1)-1:0]   count
);

  localparam int SLOT_W = $clog2(TIMERS);
  localparam int CNT_W  = $clog2(TIMERS + 1);

  logic [SLOT_W-1:0] q_r [TIMERS];
  logic [CNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      unique case (op)
        rtq_pkg::ORD_INSERT: count_r <= count_r + CNT_W'(1);
        rtq_pkg::ORD_REMOVE: count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < TIMERS; i++) begin : g_lane
    logic [SLOT_W-1:0] prev_s;
    logic [SLOT_W-1:0] next_s;

    if (i == 0) begin : g_first
      assign prev_s = slot;
    end else begin : g_mid
      assign prev_s = q_r[i-1];
    end

    if (i == TIMERS - 1) begin : g_last
      assign next_s = q_r[i];
    end else begin : g_body
      assign next_s = q_r[i+1];
    end

    always_ff @(posedge clk) begin
      unique case (op)
        rtq_pkg::ORD_INSERT: begin
          if (SLOT_W'(i) == pos) begin
            q_r[i] <= slot;
          end else if (SLOT_W'(i) > pos) begin
            q_r[i] <= prev_s;
          end
        end
        rtq_pkg::ORD_REMOVE: begin
          if (SLOT_W'(i) >= pos) begin
            q_r[i] <= next_s;
          end
        end
        default: ;
      endcase
    end
  end

  // Lowest queued position holding the requested slot.
  always_comb begin
    find_pos = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (q_r[i] == find_slot && CNT_W'(i) < count_r) begin
        find_pos = SLOT_W'(i);
      end
    end
  end

  assign rd_slot = q_r[rd_pos];
  assign count   = count_r;

endmodule

>>> test/tb_repeating_timer_queue_core.sv
module tb_repeating_timer_queue_core;

  localparam int NSLOTS = 16;
  localparam logic [2:0] ADDR_MIN_PERIOD = 3'd0;
  // Enough for a tick that requeues a full table after its last reply.
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    rtq_pkg::kind_t kind;
    logic [3:0]     slot;
    logic [31:0]    tag;
    logic [32:0]    rem;
    logic           last;
  } timer_reply_t;

  logic        clk;
  logic        rst_n;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted state of the timer table.
  logic [15:0]        min_period_ms;
  logic [47:0]        clock_ms;
  bit                 slot_busy[NSLOTS];
  logic [47:0]        slot_deadline[NSLOTS];
  logic [31:0]        slot_period[NSLOTS];
  logic signed [15:0] slot_repeats[NSLOTS];
  logic [31:0]        slot_tag[NSLOTS];
  int                 deadline_order[$];

  timer_reply_t queue_replies[$];

  int          failures;
  int          commands_sent;
  int          replies_checked;
  int          firings_predicted;
  int          settings_used;
  int unsigned hold_cycles;
  bit          steady_flow;

  repeating_timer_queue_core #(.TIMERS(NSLOTS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d replies still outstanding.", queue_replies.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic timer_reply_t reply(rtq_pkg::kind_t kind, logic [3:0] slot,
                                         logic [31:0] tag, logic [32:0] rem);
    timer_reply_t r;
    r.kind = kind;
    r.slot = slot;
    r.tag  = tag;
    r.rem  = rem;
    r.last = 1'b0;
    return r;
  endfunction

  // Equal deadlines keep their queueing order, so a new entry goes after them.
  function automatic void insert_by_deadline(int slot);
    int pos;
    pos = 0;
    while (pos < deadline_order.size() &&
           slot_deadline[deadline_order[pos]] <= slot_deadline[slot])
      pos++;
    deadline_order.insert(pos, slot);
  endfunction

  function automatic void apply_timer_command(rtq_pkg::cmd_t cmd, logic [31:0] per,
                                              logic signed [15:0] reps, logic [31:0] tag,
                                              logic [3:0] target);
    timer_reply_t batch[$];
    timer_reply_t final_reply;
    int slot;
    int due;
    int pos;
    bit found;
    logic [47:0] head;
    logic [32:0] rem;
    case (cmd)
      rtq_pkg::CMD_CREATE: begin
        slot = 0;
        while (slot < NSLOTS && slot_busy[slot]) slot++;
        if (per < min_period_ms || slot == NSLOTS) begin
          batch.push_back(reply(rtq_pkg::KIND_REJECTED, 4'd0, 32'd0, 33'd0));
        end else begin
          slot_busy[slot]     = 1'b1;
          slot_period[slot]   = per;
          slot_repeats[slot]  = reps;
          slot_tag[slot]      = tag;
          slot_deadline[slot] = clock_ms + per;
          insert_by_deadline(slot);
          batch.push_back(reply(rtq_pkg::KIND_CREATED, 4'(slot), 32'd0, 33'd0));
        end
      end
      rtq_pkg::CMD_DESTROY: begin
        if (slot_busy[target]) begin
          found = 1'b0;
          for (pos = 0; pos < deadline_order.size() && !found; pos++) begin
            if (deadline_order[pos] == int'(target)) begin
              deadline_order.delete(pos);
              found = 1'b1;
            end
          end
          slot_busy[target] = 1'b0;
          batch.push_back(reply(rtq_pkg::KIND_DESTROYED, target, 32'd0, 33'd0));
        end else begin
          batch.push_back(reply(rtq_pkg::KIND_NOT_FOUND, 4'd0, 32'd0, 33'd0));
        end
      end
      rtq_pkg::CMD_TICK: begin
        clock_ms = clock_ms + 48'd1;
        due = 0;
        while (due < deadline_order.size() && slot_deadline[deadline_order[due]] <= clock_ms)
          due++;
        if (due > rtq_pkg::MAX_FIRES) due = rtq_pkg::MAX_FIRES;
        // The due count is fixed up front, so a timer requeued at the current
        // time cannot fire twice in one tick.
        for (int f = 0; f < due; f++) begin
          slot = deadline_order.pop_front();
          batch.push_back(reply(rtq_pkg::KIND_FIRED, 4'(slot), slot_tag[slot], 33'd0));
          firings_predicted++;
          if (slot_repeats[slot] > 0) slot_repeats[slot] = slot_repeats[slot] - 16'sd1;
          if (slot_repeats[slot] == 0) begin
            slot_busy[slot] = 1'b0;
          end else begin
            slot_deadline[slot] = clock_ms + slot_period[slot];
            insert_by_deadline(slot);
          end
        end
      end
      default: begin
        if (deadline_order.size() == 0) begin
          rem = '1;
        end else begin
          head = slot_deadline[deadline_order[0]];
          if (clock_ms > head) rem = 33'd1;
          else if (head - clock_ms > 48'hFFFF_FFFF) rem = 33'h0_FFFF_FFFF;
          else rem = 33'(head - clock_ms);
        end
        batch.push_back(reply(rtq_pkg::KIND_REPORT, 4'd0, 32'd0, rem));
      end
    endcase
    if (batch.size() > 0) begin
      final_reply = batch.pop_back();
      final_reply.last = 1'b1;
      batch.push_back(final_reply);
    end
    foreach (batch[i]) queue_replies.push_back(batch[i]);
  endfunction

  function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : reply_checker
    timer_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_checked++;
      if (queue_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got kind %0d data %h", $time,
                 out_tuser, out_tdata);
        failures++;
      end else begin
        want = queue_replies.pop_front();
        check_field("kind", 33'(want.kind), 33'(out_tuser));
        check_field("slot_id", 33'(want.slot), 33'(out_tdata[3:0]));
        check_field("fired_tag", 33'(want.tag), 33'(out_tdata[35:4]));
        check_field("remaining_ms", want.rem, out_tdata[68:36]);
        check_field("last", 33'(want.last), 33'(out_tlast));
      end
    end
  end

  // Receiver: random short stalls, or a long hold-off when a test asks for one.
  initial begin : reply_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 5);
      end
    end
  end

  task automatic issue_command(rtq_pkg::cmd_t cmd, logic [31:0] per, logic signed [15:0] reps,
                               logic [31:0] tag, logic [3:0] target);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tdata  <= {4'b0, target, tag, reps, per};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    commands_sent++;
    apply_timer_command(cmd, per, reps, tag, target);
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (queue_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_period(logic [15:0] value);
    wait_quiet();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_MIN_PERIOD;
    cfg_pwdata  <= {16'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    min_period_ms = value;
    settings_used++;
  endtask

  // Runs with the reset minimum period of ten.
  task automatic test_create_destroy_query();
    issue_command(rtq_pkg::CMD_QUERY, 32'd0, 16'sd0, 32'd0, 4'd0);
    issue_command(rtq_pkg::CMD_CREATE, 32'd9, 16'sd1, 32'h1234_5678, 4'd0);
    issue_command(rtq_pkg::CMD_CREATE, 32'd10, 16'sd1, 32'hFFFF_FFFF, 4'hF);
    issue_command(rtq_pkg::CMD_CREATE, 32'hFFFF_FFFF, 16'sh8000, 32'h0000_0000, 4'd0);
    issue_command(rtq_pkg::CMD_CREATE, 32'd300, 16'sh7FFF, 32'h5A5A_A5A5, 4'd0);
    issue_command(rtq_pkg::CMD_QUERY, 32'hFFFF_FFFF, 16'shFFFF, 32'hFFFF_FFFF, 4'hF);
    issue_command(rtq_pkg::CMD_DESTROY, 32'd0, 16'sd0, 32'd0, 4'd15);
    issue_command(rtq_pkg::CMD_DESTROY, 32'hFFFF_FFFF, 16'shFFFF, 32'hFFFF_FFFF, 4'd1);
    issue_command(rtq_pkg::CMD_DESTROY, 32'd0, 16'sd0, 32'd0, 4'd1);
  endtask

  // Zero-period and forever timers: requeued entries land behind other due ones.
  task automatic test_firing_order();
    issue_command(rtq_pkg::CMD_CREATE, 32'd0, 16'sd2, 32'hC0DE_0001, 4'd0);
    issue_command(rtq_pkg::CMD_CREATE, 32'd1, 16'shFFFF, 32'hC0DE_0002, 4'd0);
    issue_command(rtq_pkg::CMD_QUERY, 32'd0, 16'sd0, 32'd0, 4'd0);
    issue_command(rtq_pkg::CMD_TICK, 32'd0, 16'sd0, 32'd0, 4'd0);
    issue_command(rtq_pkg::CMD_TICK, 32'd0, 16'sd0, 32'd0, 4'd0);
    issue_command(rtq_pkg::CMD_DESTROY, 32'd0, 16'sd0, 32'd0, 4'd3);
    issue_command(rtq_pkg::CMD_TICK, 32'd0, 16'sd0, 32'd0, 4'd0);
    issue_command(rtq_pkg::CMD_QUERY, 32'd0, 16'sd0, 32'd0, 4'd0);
  endtask

  // Starts filling the table under a long receiver hold-off, then fires all sixteen at once.
  task automatic test_full_table_burst();
    for (int s = 0; s < NSLOTS; s++)
      if (slot_busy[s])
        issue_command(rtq_pkg::CMD_DESTROY, $urandom, 16'($urandom), $urandom, 4'(s));
    hold_cycles = 400;
    for (int s = 0; s <= NSLOTS; s++)
      issue_command(rtq_pkg::CMD_CREATE, 32'd5, 16'sd1, $urandom, 4'($urandom));
    repeat (5)
      issue_command(rtq_pkg::CMD_TICK, $urandom, 16'($urandom), $urandom, 4'($urandom));
  endtask

  task automatic test_long_periods();
    issue_command(rtq_pkg::CMD_CREATE, 32'd65534, 16'sd1, $urandom, 4'd0);
    issue_command(rtq_pkg::CMD_CREATE, 32'd65535, 16'sd0, $urandom, 4'd0);
    issue_command(rtq_pkg::CMD_CREATE, 32'hFFFF_FFFF, 16'sh7FFF, $urandom, 4'd0);
    issue_command(rtq_pkg::CMD_QUERY, 32'd0, 16'sd0, 32'd0, 4'd0);
    repeat (4)
      issue_command(rtq_pkg::CMD_CREATE, $urandom, 16'($urandom), $urandom, 4'($urandom));
    issue_command(rtq_pkg::CMD_TICK, 32'd0, 16'sd0, 32'd0, 4'd0);
    issue_command(rtq_pkg::CMD_QUERY, 32'd0, 16'sd0, 32'd0, 4'd0);
    for (int s = 0; s < NSLOTS; s++)
      if (slot_busy[s])
        issue_command(rtq_pkg::CMD_DESTROY, $urandom, 16'($urandom), $urandom, 4'(s));
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    logic [31:0] per;
    logic signed [15:0] reps;
    logic [3:0] target;
    for (int n = 0; n < count; n++) begin
      if (n == count - 30) steady_flow = 1'b1;
      pick = $urandom_range(0, 99);
      per = $urandom_range(min_period_ms, min_period_ms + 12);
      if ($urandom_range(0, 9) == 0) per = $urandom;
      else if (min_period_ms > 0 && $urandom_range(0, 9) == 0) per = min_period_ms - 1;
      case ($urandom_range(0, 7))
        0:       reps = 16'($urandom);
        1:       reps = -16'sd1;
        default: reps = 16'($urandom_range(0, 4));
      endcase
      // Destroys mostly aim at a live timer.
      target = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 4) != 0)
        repeat (NSLOTS) if (!slot_busy[target]) target = target + 4'd1;
      if (pick < 25)      issue_command(rtq_pkg::CMD_CREATE, per, reps, $urandom, target);
      else if (pick < 38) issue_command(rtq_pkg::CMD_DESTROY, per, reps, $urandom, target);
      else if (pick < 88) issue_command(rtq_pkg::CMD_TICK, per, reps, $urandom, target);
      else                issue_command(rtq_pkg::CMD_QUERY, per, reps, $urandom, target);
    end
  endtask

  initial begin
    failures          = 0;
    commands_sent     = 0;
    replies_checked   = 0;
    firings_predicted = 0;
    settings_used     = 0;
    hold_cycles       = 0;
    steady_flow       = 1'b0;
    min_period_ms     = rtq_pkg::MIN_PERIOD_RST;
    clock_ms          = '0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_create_destroy_query();
    write_min_period(16'd0);
    test_firing_order();
    write_min_period(16'd3);
    test_full_table_burst();
    write_min_period(16'hFFFF);
    test_long_periods();
    write_min_period(16'($urandom_range(1, 6)));
    test_random_traffic(115);
    wait_quiet();

    $display("Sent %0d commands and checked %0d replies, %0d of them timer firings.",
             commands_sent, replies_checked, firings_predicted);
    $display("Used %0d minimum-period settings, a full-table burst and one long output stall.",
             settings_used);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rtq_pkg.sv
sv/rtq_ram.sv
sv/rtq_alu.sv
sv/rtq_order.sv
sv/repeating_timer_queue_core.sv
test/tb_repeating_timer_queue_core.sv
